FILE: rtl/stft_pkg.sv
// Shared types, constants and the quarter-wave sine table for the STFT spectrogram block.
package stft_pkg;

    localparam int unsigned WIN_LEN    = 256;
    localparam int unsigned ADDR_W     = 8;
    localparam int unsigned WORK_W     = 26;
    localparam int unsigned CPLX_W     = 2 * WORK_W;
    localparam int unsigned MAG_W      = 24;
    localparam int unsigned RAD_W      = 2 * WORK_W;
    localparam int unsigned ROOT_W     = WORK_W;

    localparam logic [7:0]  BIN_LIMIT  = 8'd129;
    localparam logic [6:0]  LAST_BASE  = 7'd126;
    localparam logic [15:0] SEEN_MAX   = 16'hFFFF;
    localparam logic [15:0] SEEN_FULL  = 16'd256;

    typedef enum logic [1:0] {
        REG_HOP_SIZE    = 2'd0,
        REG_FRAME_COUNT = 2'd1
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LD_RD,
        ST_LD_MUL,
        ST_LD_WR,
        ST_BF_RD,
        ST_BF_MUL,
        ST_BF_ADD,
        ST_BF_WP,
        ST_BF_WQ,
        ST_MG_RD,
        ST_MG_SQ,
        ST_MG_SUM,
        ST_MG_ROOT,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               first;
    } smp_t;

    typedef struct packed {
        logic [7:0]  frame_index;
        logic [6:0]  bin_index;
        logic [23:0] mag_a;
        logic [23:0] mag_b;
        logic [23:0] mag_c;
        logic        last;
    } res_t;

    // round(32768 * sin(2*pi*i/256)) for the first quarter wave
    localparam logic [16:0] QUARTER_SINE [0:64] = '{
        17'd0,     17'd804,   17'd1608,  17'd2411,  17'd3212,  17'd4011,
        17'd4808,  17'd5602,  17'd6393,  17'd7180,  17'd7962,  17'd8740,
        17'd9512,  17'd10279, 17'd11039, 17'd11793, 17'd12540, 17'd13279,
        17'd14010, 17'd14733, 17'd15447, 17'd16151, 17'd16846, 17'd17531,
        17'd18205, 17'd18868, 17'd19520, 17'd20160, 17'd20788, 17'd21403,
        17'd22006, 17'd22595, 17'd23170, 17'd23732, 17'd24279, 17'd24812,
        17'd25330, 17'd25833, 17'd26320, 17'd26791, 17'd27246, 17'd27684,
        17'd28106, 17'd28511, 17'd28899, 17'd29269, 17'd29622, 17'd29957,
        17'd30274, 17'd30572, 17'd30853, 17'd31114, 17'd31357, 17'd31581,
        17'd31786, 17'd31972, 17'd32138, 17'd32286, 17'd32413, 17'd32522,
        17'd32610, 17'd32679, 17'd32729, 17'd32758, 17'd32768
    };

    function automatic logic signed [16:0] sine_at(input logic [7:0] m);
        logic [6:0]  r;
        logic [16:0] v;
        r = {1'b0, m[5:0]};
        v = m[6] ? QUARTER_SINE[7'd64 - r] : QUARTER_SINE[r];
        return m[7] ? -$signed(v) : $signed(v);
    endfunction

    function automatic logic signed [16:0] cosine_at(input logic [7:0] m);
        return sine_at(m + 8'd64);
    endfunction

    function automatic logic [7:0] bit_reverse(input logic [7:0] v);
        logic [7:0] r;
        for (int b = 0; b < 8; b++) begin
            r[b] = v[7 - b];
        end
        return r;
    endfunction

    function automatic logic signed [25:0] sat26(input logic signed [29:0] v);
        if (v > 30'sd33554431) begin
            return 26'sd33554431;
        end
        if (v < -30'sd33554432) begin
            return -26'sd33554432;
        end
        return v[25:0];
    endfunction

endpackage

FILE: rtl/stft_magnitude_spectrogram.sv
// STFT magnitude spectrogram: 256-point Hann-windowed radix-2 FFT, 129 bin magnitudes.
//
// Samples arrive on the smp channel (valid/ready), one per transfer. The block keeps
// the last 256 samples in a history RAM. Sample 255 of a recording, and every
// hop_size samples after that, starts a frame, up to frame_count frames; a sample
// with first set clears the counters before it is counted.
// A frame runs in place in a work RAM (two copies for two read ports): a windowed load
// of each sample (read, multiply, write), each butterfly through four multipliers
// (read, multiply, add, write p, write q), then for each bin a read, a squaring, and a
// 26-bit bit-serial square root. smp_ready stays low for the whole frame.
// Results leave on the res channel, three bins per transfer, 43 transfers per frame, last
// set on bins 126..128. A result waits in its register while res_ready is low, and the
// block holds until it is taken. Reset clears counters and restores hop_size 128 and
// frame_count 124. Configuration is written through cfg_we, cfg_index and cfg_data; the
// user must write it only while the block is idle, which the block does not enforce.
module stft_magnitude_spectrogram (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            smp_valid,
    output logic            smp_ready,
    input  stft_pkg::smp_t  smp,
    output logic            res_valid,
    input  logic            res_ready,
    output stft_pkg::res_t  res,
    input  logic            cfg_we,
    input  logic [1:0]      cfg_index,
    input  logic [8:0]      cfg_data
);

    import stft_pkg::*;

    state_t      state_reg, state_next;
    logic [8:0]  hop_size_reg, hop_size_next;
    logic [7:0]  frame_count_reg, frame_count_next;
    logic [15:0] seen_reg, seen_next;
    logic [8:0]  hop_reg, hop_next;
    logic [7:0]  frames_reg, frames_next;
    logic [7:0]  wp_reg, wp_next;
    logic [7:0]  idx_reg, idx_next;
    logic [2:0]  stage_reg, stage_next;
    logic [6:0]  bfly_reg, bfly_next;
    logic [6:0]  base_reg, base_next;
    logic [1:0]  j_reg, j_next;

    logic signed [33:0] prod_reg, prod_next;
    logic signed [42:0] pac_reg, pac_next, pbs_reg, pbs_next;
    logic signed [42:0] pbc_reg, pbc_next, pas_reg, pas_next;
    logic signed [25:0] ur_reg, ur_next, ui_reg, ui_next;
    logic signed [25:0] pr_reg, pr_next, pi_reg, pi_next;
    logic signed [25:0] qr_reg, qr_next, qi_reg, qi_next;
    logic [50:0] sqr_reg, sqr_next, sqi_reg, sqi_next;
    logic [23:0] mag_reg [3];
    logic [23:0] mag_next [3];

    logic        accept;
    logic        hist_we;
    logic [7:0]  hist_waddr;
    logic [15:0] hist_q;
    logic        work_we;
    logic [7:0]  work_waddr;
    logic [CPLX_W-1:0] work_wdata;
    logic [7:0]  raddr_p, raddr_q;
    logic [CPLX_W-1:0] work_qp, work_qq;

    logic        sqrt_start;
    logic        sqrt_done;
    logic [ROOT_W-1:0] sqrt_root;
    logic [RAD_W-1:0]  radicand;

    logic [7:0]  half, mask, bfly_w, kk, addr_p, addr_q, tw_m, bin;
    logic signed [16:0] tw_c, tw_s;
    logic signed [17:0] hann;
    logic signed [25:0] qa, qb, pa_re, pa_im;
    logic signed [43:0] sum_r, sum_i;
    logic signed [28:0] tr, ti;
    logic signed [18:0] win_v;
    logic signed [51:0] re_sq, im_sq;

    // butterfly addressing for the current stage
    assign half   = 8'd1 << stage_reg;
    assign mask   = half - 8'd1;
    assign bfly_w = {1'b0, bfly_reg};
    assign kk     = bfly_w & mask;
    assign addr_p = ((bfly_w & ~mask) << 1) | kk;
    assign addr_q = addr_p | half;
    assign tw_m   = kk << (3'd7 - stage_reg);
    assign tw_c   = cosine_at(tw_m);
    assign tw_s   = sine_at(tw_m);
    assign bin    = {1'b0, base_reg} + {6'd0, j_reg};
    assign hann   = 18'((18'sd32768 - 18'(cosine_at(idx_reg))) >>> 1);

    assign qa    = work_qq[CPLX_W-1:WORK_W];
    assign qb    = work_qq[WORK_W-1:0];
    assign pa_re = work_qp[CPLX_W-1:WORK_W];
    assign pa_im = work_qp[WORK_W-1:0];

    assign sum_r = 44'(pac_reg) + 44'(pbs_reg) + 44'sd16384;
    assign sum_i = 44'(pbc_reg) - 44'(pas_reg) + 44'sd16384;
    assign tr    = sum_r[43:15];
    assign ti    = sum_i[43:15];
    assign win_v = 19'((prod_reg + 34'sd16384) >>> 15);
    assign re_sq = 52'(pa_re) * 52'(pa_re);
    assign im_sq = 52'(pa_im) * 52'(pa_im);
    assign radicand = {1'b0, sqr_reg} + {1'b0, sqi_reg};

    assign raddr_p = (state_reg == ST_MG_RD) ? bin : addr_p;
    assign raddr_q = addr_q;

    assign accept    = smp_valid && smp_ready;
    assign smp_ready = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_OUT);

    always_comb
    begin
        logic [15:0] seen_e;
        logic [8:0]  hop_e;
        logic [7:0]  frames_e;
        logic [7:0]  wp_e;
        logic [8:0]  hop_inc;
        logic        emit;

        state_next       = state_reg;
        hop_size_next    = hop_size_reg;
        frame_count_next = frame_count_reg;
        seen_next        = seen_reg;
        hop_next         = hop_reg;
        frames_next      = frames_reg;
        wp_next          = wp_reg;
        idx_next         = idx_reg;
        stage_next       = stage_reg;
        bfly_next        = bfly_reg;
        base_next        = base_reg;
        j_next           = j_reg;
        prod_next        = prod_reg;
        pac_next         = pac_reg;
        pbs_next         = pbs_reg;
        pbc_next         = pbc_reg;
        pas_next         = pas_reg;
        ur_next          = ur_reg;
        ui_next          = ui_reg;
        pr_next          = pr_reg;
        pi_next          = pi_reg;
        qr_next          = qr_reg;
        qi_next          = qi_reg;
        sqr_next         = sqr_reg;
        sqi_next         = sqi_reg;
        mag_next         = mag_reg;
        hist_we          = 1'b0;
        hist_waddr       = wp_reg;
        work_we          = 1'b0;
        work_waddr       = addr_p;
        work_wdata       = {pr_reg, pi_reg};
        sqrt_start       = 1'b0;
        seen_e           = smp.first ? '0 : seen_reg;
        hop_e            = smp.first ? '0 : hop_reg;
        frames_e         = smp.first ? '0 : frames_reg;
        wp_e             = smp.first ? '0 : wp_reg;
        hop_inc          = hop_e + 9'd1;
        emit             = 1'b0;

        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_HOP_SIZE:    hop_size_next    = cfg_data;
                REG_FRAME_COUNT: frame_count_next = cfg_data[7:0];
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    seen_next   = seen_e;
                    hop_next    = hop_e;
                    frames_next = frames_e;
                    wp_next     = wp_e;
                    if (frames_e < frame_count_reg)
                    begin
                        hist_we    = 1'b1;
                        hist_waddr = wp_e;
                        wp_next    = wp_e + 8'd1;
                        if (seen_e != SEEN_MAX)
                        begin
                            seen_next = seen_e + 16'd1;
                        end
                        if (seen_next == SEEN_FULL)
                        begin
                            emit     = 1'b1;
                            hop_next = '0;
                        end
                        else if (seen_next > SEEN_FULL)
                        begin
                            hop_next = hop_inc;
                            if (hop_inc == hop_size_reg)
                            begin
                                emit     = 1'b1;
                                hop_next = '0;
                            end
                        end
                        if (emit)
                        begin
                            idx_next   = '0;
                            state_next = ST_LD_RD;
                        end
                    end
                end
            end
            ST_LD_RD:
            begin
                state_next = ST_LD_MUL;
            end
            ST_LD_MUL:
            begin
                prod_next  = 34'($signed(hist_q)) * 34'(hann);
                state_next = ST_LD_WR;
            end
            ST_LD_WR:
            begin
                work_we    = 1'b1;
                work_waddr = bit_reverse(idx_reg);
                work_wdata = {26'(win_v), 26'd0};
                idx_next   = idx_reg + 8'd1;
                if (idx_reg == 8'd255)
                begin
                    stage_next = '0;
                    bfly_next  = '0;
                    state_next = ST_BF_RD;
                end
                else
                begin
                    state_next = ST_LD_RD;
                end
            end
            ST_BF_RD:
            begin
                state_next = ST_BF_MUL;
            end
            ST_BF_MUL:
            begin
                pac_next   = 43'(qa) * 43'(tw_c);
                pbs_next   = 43'(qb) * 43'(tw_s);
                pbc_next   = 43'(qb) * 43'(tw_c);
                pas_next   = 43'(qa) * 43'(tw_s);
                ur_next    = pa_re;
                ui_next    = pa_im;
                state_next = ST_BF_ADD;
            end
            ST_BF_ADD:
            begin
                pr_next    = sat26(30'(ur_reg) + 30'(tr));
                pi_next    = sat26(30'(ui_reg) + 30'(ti));
                qr_next    = sat26(30'(ur_reg) - 30'(tr));
                qi_next    = sat26(30'(ui_reg) - 30'(ti));
                state_next = ST_BF_WP;
            end
            ST_BF_WP:
            begin
                work_we    = 1'b1;
                work_waddr = addr_p;
                work_wdata = {pr_reg, pi_reg};
                state_next = ST_BF_WQ;
            end
            ST_BF_WQ:
            begin
                work_we    = 1'b1;
                work_waddr = addr_q;
                work_wdata = {qr_reg, qi_reg};
                bfly_next  = bfly_reg + 7'd1;
                state_next = ST_BF_RD;
                if (bfly_reg == 7'd127)
                begin
                    stage_next = stage_reg + 3'd1;
                    if (stage_reg == 3'd7)
                    begin
                        base_next  = '0;
                        j_next     = '0;
                        state_next = ST_MG_RD;
                    end
                end
            end
            ST_MG_RD:
            begin
                if (bin < BIN_LIMIT)
                begin
                    state_next = ST_MG_SQ;
                end
                else
                begin
                    // bins past Nyquist read as zero
                    mag_next[j_reg] = '0;
                    j_next          = j_reg + 2'd1;
                    state_next      = (j_reg == 2'd2) ? ST_OUT : ST_MG_RD;
                end
            end
            ST_MG_SQ:
            begin
                sqr_next   = re_sq[50:0];
                sqi_next   = im_sq[50:0];
                state_next = ST_MG_SUM;
            end
            ST_MG_SUM:
            begin
                sqrt_start = 1'b1;
                state_next = ST_MG_ROOT;
            end
            ST_MG_ROOT:
            begin
                if (sqrt_done)
                begin
                    mag_next[j_reg] = (sqrt_root[ROOT_W-1:MAG_W] != '0) ? '1
                                                                          : sqrt_root[MAG_W-1:0];
                    j_next          = j_reg + 2'd1;
                    state_next      = (j_reg == 2'd2) ? ST_OUT : ST_MG_RD;
                end
            end
            ST_OUT:
            begin
                if (res_ready)
                begin
                    j_next = '0;
                    if (base_reg == LAST_BASE)
                    begin
                        frames_next = frames_reg + 8'd1;
                        state_next  = ST_IDLE;
                    end
                    else
                    begin
                        base_next  = base_reg + 7'd3;
                        state_next = ST_MG_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            hop_size_reg    <= 9'd128;
            frame_count_reg <= 8'd124;
            seen_reg        <= '0;
            hop_reg         <= '0;
            frames_reg      <= '0;
            wp_reg          <= '0;
            idx_reg         <= '0;
            stage_reg       <= '0;
            bfly_reg        <= '0;
            base_reg        <= '0;
            j_reg           <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            hop_size_reg    <= hop_size_next;
            frame_count_reg <= frame_count_next;
            seen_reg        <= seen_next;
            hop_reg         <= hop_next;
            frames_reg      <= frames_next;
            wp_reg          <= wp_next;
            idx_reg         <= idx_next;
            stage_reg       <= stage_next;
            bfly_reg        <= bfly_next;
            base_reg        <= base_next;
            j_reg           <= j_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        pac_reg  <= pac_next;
        pbs_reg  <= pbs_next;
        pbc_reg  <= pbc_next;
        pas_reg  <= pas_next;
        ur_reg   <= ur_next;
        ui_reg   <= ui_next;
        pr_reg   <= pr_next;
        pi_reg   <= pi_next;
        qr_reg   <= qr_next;
        qi_reg   <= qi_next;
        sqr_reg  <= sqr_next;
        sqi_reg  <= sqi_next;
        mag_reg  <= mag_next;
    end

    stft_ram #(
        .WIDTH (16),
        .DEPTH (256)
    ) u_hist (
        .clk   (clk),
        .we    (hist_we),
        .waddr (hist_waddr),
        .wdata (smp.sample),
        .raddr (wp_reg + idx_reg),
        .rdata (hist_q)
    );

    stft_ram #(
        .WIDTH (52),
        .DEPTH (256)
    ) u_work_p (
        .clk   (clk),
        .we    (work_we),
        .waddr (work_waddr),
        .wdata (work_wdata),
        .raddr (raddr_p),
        .rdata (work_qp)
    );

    stft_ram #(
        .WIDTH (52),
        .DEPTH (256)
    ) u_work_q (
        .clk   (clk),
        .we    (work_we),
        .waddr (work_waddr),
        .wdata (work_wdata),
        .raddr (raddr_q),
        .rdata (work_qq)
    );

    stft_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (radicand),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    assign res.frame_index = frames_reg;
    assign res.bin_index   = base_reg;
    assign res.mag_a       = mag_reg[0];
    assign res.mag_b       = mag_reg[1];
    assign res.mag_c       = mag_reg[2];
    assign res.last        = (base_reg == LAST_BASE);

endmodule

FILE: rtl/stft_ram.sv
// Generic single-write, single-read memory with registered read data.
module stft_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/stft_sqrt.sv
// Bit-serial floor square root, one root bit per cycle.
module stft_sqrt (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [stft_pkg::RAD_W-1:0]       radicand,
    output logic                             done,
    output logic [stft_pkg::ROOT_W-1:0]      root
);

    import stft_pkg::*;

    localparam int CNT_W = $clog2(ROOT_W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [RAD_W-1:0] rad_reg, rad_next;
    logic [27:0]      rem_reg, rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [29:0]      rem_sh;
    logic [29:0]      trial;

    assign rem_sh = {rem_reg, rad_reg[RAD_W-1 -: 2]};
    assign trial  = {2'b00, root_reg, 2'b01};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
        end
        else if (busy_reg)
        begin
            rad_next = {rad_reg[RAD_W-3:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_next  = 28'(rem_sh - trial);
                root_next = {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh[27:0];
                root_next = {root_reg[ROOT_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(ROOT_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

FILE: tb/sv/tb_stft_magnitude_spectrogram.sv
// Self-checking testbench for the STFT magnitude spectrogram block.
module tb_stft_magnitude_spectrogram;
    import stft_pkg::*;

    localparam int FRAME_ROWS = 43;

    logic       clk;
    logic       rst_n;
    logic       smp_valid;
    logic       smp_ready;
    smp_t       smp;
    logic       res_valid;
    logic       res_ready;
    res_t       res;
    logic       cfg_we;
    logic [1:0] cfg_index;
    logic [8:0] cfg_data;

    stft_magnitude_spectrogram u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .smp_valid (smp_valid),
        .smp_ready (smp_ready),
        .smp       (smp),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    typedef enum int {
        SRC_RANDOM,
        SRC_QUIET,
        SRC_EXTREME,
        SRC_FULL_SCALE,
        SRC_NYQUIST
    } src_kind_t;

    typedef struct {
        logic signed [15:0] sample;
        logic               first;
    } stim_row_t;

    // shadow of the block state
    logic signed [15:0] history [0:255];
    logic [7:0]         wr_ptr;
    int unsigned        seen_cnt;
    logic [8:0]         hop_cnt;
    logic [7:0]         frames_cnt;
    logic [8:0]         hop_cfg;
    logic [7:0]         count_cfg;
    longint             work_re [0:255];
    longint             work_im [0:255];

    res_t spectrum_rows_q [$];
    int   mismatches = 0;
    int   sender_idle_pct;
    int   stall_pct;

    function automatic longint sine_q15(int m);
        int q;
        int r;
        longint v;
        q = (m >> 6) & 3;
        r = m & 63;
        v = (q & 1) ? longint'(QUARTER_SINE[64 - r]) : longint'(QUARTER_SINE[r]);
        return (q & 2) ? -v : v;
    endfunction

    function automatic longint cosine_q15(int m);
        return sine_q15((m + 64) & 255);
    endfunction

    function automatic longint clip26(longint v);
        if (v > 64'sd33554431) return 64'sd33554431;
        if (v < -64'sd33554432) return -64'sd33554432;
        return v;
    endfunction

    function automatic longint rnd_q15(longint v);
        return (v + 16384) >>> 15;
    endfunction

    function automatic logic [23:0] mag_of(int bin);
        longint unsigned n;
        longint unsigned r;
        longint unsigned b;
        n = longint'(work_re[bin] * work_re[bin]) + longint'(work_im[bin] * work_im[bin]);
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return (r > 64'd16777215) ? 24'hFFFFFF : r[23:0];
    endfunction

    task automatic transform_window();
        int i;
        int d;
        int len;
        int half;
        int base;
        int k;
        int p;
        int q;
        longint c;
        longint s;
        longint tr;
        longint ti;
        longint ur;
        longint ui;
        for (i = 0; i < 256; i++)
        begin
            d = 0;
            for (int b = 0; b < 8; b++) d = (d << 1) | ((i >> b) & 1);
            work_re[d] = clip26(rnd_q15(longint'(history[(wr_ptr + i) & 255])
                                 * ((32768 - cosine_q15(i)) >>> 1)));
            work_im[d] = 0;
        end
        for (len = 2; len <= 256; len = len * 2)
        begin
            half = len / 2;
            for (base = 0; base < 256; base += len)
            begin
                for (k = 0; k < half; k++)
                begin
                    p = base + k;
                    q = base + k + half;
                    c = cosine_q15((k * (256 / len)) & 255);
                    s = sine_q15((k * (256 / len)) & 255);
                    tr = rnd_q15(work_re[q] * c + work_im[q] * s);
                    ti = rnd_q15(work_im[q] * c - work_re[q] * s);
                    ur = work_re[p];
                    ui = work_im[p];
                    work_re[p] = clip26(ur + tr);
                    work_im[p] = clip26(ui + ti);
                    work_re[q] = clip26(ur - tr);
                    work_im[q] = clip26(ui - ti);
                end
            end
        end
    endtask

    // advance the shadow state by one accepted sample, queue any frame it emits
    task automatic predict_spectrum(smp_t s);
        logic emit;
        res_t row;
        int bin;
        emit = 1'b0;
        if (s.first)
        begin
            seen_cnt = 0;
            hop_cnt = '0;
            frames_cnt = '0;
            wr_ptr = '0;
        end
        if (frames_cnt >= count_cfg) return;
        history[wr_ptr] = s.sample;
        wr_ptr = wr_ptr + 8'd1;
        if (seen_cnt < 65535) seen_cnt++;
        if (seen_cnt == 256)
        begin
            emit = 1'b1;
            hop_cnt = '0;
        end
        else if (seen_cnt > 256)
        begin
            hop_cnt = hop_cnt + 9'd1;
            if (hop_cnt == hop_cfg)
            begin
                emit = 1'b1;
                hop_cnt = '0;
            end
        end
        if (!emit) return;
        transform_window();
        for (int k = 0; k < FRAME_ROWS; k++)
        begin
            bin = 3 * k;
            row.frame_index = frames_cnt;
            row.bin_index = bin[6:0];
            row.mag_a = (bin < 129) ? mag_of(bin) : '0;
            row.mag_b = (bin + 1 < 129) ? mag_of(bin + 1) : '0;
            row.mag_c = (bin + 2 < 129) ? mag_of(bin + 2) : '0;
            row.last = (k == FRAME_ROWS - 1);
            spectrum_rows_q.push_back(row);
        end
        frames_cnt = frames_cnt + 8'd1;
    endtask

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #100000000;
        $display("** stft_magnitude_spectrogram: FAILED **");
        $finish;
    end

    always @(negedge clk)
    begin
        res_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        res_t want;
        if (res_valid && res_ready)
        begin
            if (spectrum_rows_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: frame %0d bin %0d",
                             res.frame_index, res.bin_index);
            end
            else
            begin
                want = spectrum_rows_q.pop_front();
                if (res !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp f%0d b%0d %0d %0d %0d l%0d",
                                 want.frame_index, want.bin_index, want.mag_a, want.mag_b,
                                 want.mag_c, want.last,
                                 " got f%0d b%0d %0d %0d %0d l%0d",
                                 res.frame_index, res.bin_index,
                                 res.mag_a, res.mag_b, res.mag_c, res.last);
                end
            end
        end
    end

    task automatic send_sample(logic signed [15:0] value, logic first);
        smp_t s;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            smp_valid = 1'b0;
            @(negedge clk);
        end
        s.sample = value;
        s.first = first;
        smp = s;
        smp_valid = 1'b1;
        do @(posedge clk); while (!smp_ready);
        predict_spectrum(s);
        @(negedge clk);
    endtask

    // write only once the block has drained
    task automatic write_reg(cfg_reg_t idx, logic [8:0] value);
        smp_valid = 1'b0;
        while (spectrum_rows_q.size() != 0) @(negedge clk);
        repeat (20) @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == REG_HOP_SIZE) hop_cfg = value;
        else count_cfg = value[7:0];
    endtask

    function automatic logic signed [15:0] pick_sample(src_kind_t kind, int i);
        logic signed [15:0] corner [4];
        corner = '{16'sh7FFF, -16'sh8000, 16'sh0000, -16'sh0001};
        case (kind)
            SRC_QUIET:      return $signed(16'($urandom_range(128))) - 16'sd64;
            SRC_EXTREME:    return corner[$urandom_range(3)];
            SRC_FULL_SCALE: return 16'sh7FFF;
            SRC_NYQUIST:    return (i & 1) ? -16'sh8000 : 16'sh7FFF;
            default:        return 16'($urandom);
        endcase
    endfunction

    function automatic src_kind_t kind_at(int i);
        if (i < 128) return SRC_EXTREME;
        if (i < 160) return SRC_FULL_SCALE;
        if (i < 192) return SRC_NYQUIST;
        if (i < 224) return SRC_QUIET;
        return SRC_RANDOM;
    endfunction

    stim_row_t quiet_rows [] = '{
        '{16'sh7FFF, 1'b1}, '{-16'sh8000, 1'b0}, '{16'sh0000, 1'b0}, '{-16'sh0001, 1'b0},
        '{16'sh5555, 1'b1}, '{-16'sh5556, 1'b0}, '{16'sh0001, 1'b1}, '{16'sh4000, 1'b0},
        '{-16'sh4000, 1'b0}, '{16'sh7FFE, 1'b1}, '{16'sh00FF, 1'b0}, '{-16'sh0100, 1'b0}
    };

    initial
    begin
        rst_n = 1'b0;
        smp_valid = 1'b0;
        smp = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        sender_idle_pct = 0;
        stall_pct = 0;
        seen_cnt = 0;
        hop_cnt = '0;
        frames_cnt = '0;
        wr_ptr = '0;
        hop_cfg = 9'd128;
        count_cfg = 8'd124;
        for (int i = 0; i < 256; i++) history[i] = '0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // frame count zero: every sample is dropped, any result is unexpected
        write_reg(REG_FRAME_COUNT, 9'd0);
        foreach (quiet_rows[i]) send_sample(quiet_rows[i].sample, quiet_rows[i].first);

        // hop of one, four frames, then samples past the last frame;
        // the idling phase changes along the recording
        write_reg(REG_HOP_SIZE, 9'd1);
        write_reg(REG_FRAME_COUNT, 9'd4);
        for (int i = 0; i < 262; i++)
        begin
            if (i < 96)
            begin
                sender_idle_pct = 82;
                stall_pct = 0;
            end
            else if (i < 256 || i == 258)
            begin
                sender_idle_pct = 0;
                stall_pct = 0;
            end
            else if (i == 257)
            begin
                sender_idle_pct = 12;
                stall_pct = 12;
            end
            else
            begin
                sender_idle_pct = 0;
                stall_pct = 82;
            end
            // a stray restart now and then breaks a recording
            send_sample(pick_sample(kind_at(i), i), (i == 0) || ($urandom_range(999) == 0));
        end

        smp_valid = 1'b0;
        while (spectrum_rows_q.size() != 0) @(negedge clk);
        repeat (50) @(negedge clk);
        if (mismatches == 0 && spectrum_rows_q.size() == 0)
        begin
            $display("** stft_magnitude_spectrogram: PASSED **");
        end
        else
        begin
            $display("** stft_magnitude_spectrogram: FAILED **");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/stft_pkg.sv
rtl/stft_ram.sv
rtl/stft_sqrt.sv
rtl/stft_magnitude_spectrogram.sv
tb/sv/tb_stft_magnitude_spectrogram.sv
